// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge outside reset
`define ASSERT_CLKRST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/wsh_pkg.sv =====
package wsh_pkg;

  typedef enum logic {
    OP_PARSE  = 1'b0,
    OP_ENCODE = 1'b1
  } op_t;

  typedef enum logic {
    KIND_SUMMARY = 1'b0,
    KIND_BYTE    = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    LEN_7  = 2'd0,
    LEN_16 = 2'd1,
    LEN_64 = 2'd2
  } len_kind_t;

  localparam logic [6:0]  LEN_CODE_16  = 7'd126;
  localparam logic [6:0]  LEN_CODE_64  = 7'd127;
  localparam logic [63:0] LEN_LIMIT_7  = 64'd126;
  localparam logic [63:0] LEN_LIMIT_16 = 64'h10000;

  localparam logic [3:0] HDR_BASE   = 4'd2;
  localparam logic [3:0] KEY_BYTES  = 4'd4;
  localparam logic [3:0] EXT_BYTES_16 = 4'd2;
  localparam logic [3:0] EXT_BYTES_64 = 4'd8;

  localparam logic [3:0] OPC_CONT    = 4'h0;
  localparam logic [3:0] OPC_TEXT    = 4'h1;
  localparam logic [3:0] OPC_BINARY  = 4'h2;
  localparam logic [3:0] OPC_UNKNOWN = 4'h3;
  localparam logic [3:0] OPC_CLOSE   = 4'h8;
  localparam logic [3:0] OPC_PING    = 4'h9;
  localparam logic [3:0] OPC_PONG    = 4'hA;

  localparam logic [2:0] CLS_CONT    = 3'd0;
  localparam logic [2:0] CLS_TEXT    = 3'd1;
  localparam logic [2:0] CLS_BINARY  = 3'd2;
  localparam logic [2:0] CLS_CLOSE   = 3'd3;
  localparam logic [2:0] CLS_PING    = 3'd4;
  localparam logic [2:0] CLS_PONG    = 3'd5;
  localparam logic [2:0] CLS_UNKNOWN = 3'd6;

  // slave word, rx_byte in the lowest bits
  typedef struct packed {
    logic [2:0]  pad;
    logic [31:0] tx_key;
    logic [63:0] tx_length;
    logic        tx_masked;
    logic [2:0]  tx_opcode_class;
    logic        tx_fin;
    logic [7:0]  rx_byte;
  } in_word_t;

  // master word, tx_byte in the lowest bits
  typedef struct packed {
    logic [6:0]  pad;
    logic [3:0]  header_bytes;
    logic [31:0] rx_key;
    logic [63:0] rx_length;
    logic        rx_masked;
    logic [2:0]  rx_opcode_class;
    logic        rx_fin;
    logic [7:0]  tx_byte;
  } out_word_t;

  typedef struct packed {
    logic        fin;
    logic [2:0]  opcode_class;
    logic        masked;
    logic [63:0] length;
    logic [31:0] key;
    logic [3:0]  header_bytes;
  } summary_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [3:0] count;
  } enc_out_t;

  function automatic logic [2:0] class_of_opcode(input logic [3:0] code);
    logic [2:0] cls;
    unique case (code)
      OPC_CONT:   cls = CLS_CONT;
      OPC_TEXT:   cls = CLS_TEXT;
      OPC_BINARY: cls = CLS_BINARY;
      OPC_CLOSE:  cls = CLS_CLOSE;
      OPC_PING:   cls = CLS_PING;
      OPC_PONG:   cls = CLS_PONG;
      default:    cls = CLS_UNKNOWN;
    endcase
    return cls;
  endfunction

  function automatic logic [3:0] opcode_of_class(input logic [2:0] cls);
    logic [3:0] code;
    unique case (cls)
      CLS_CONT:   code = OPC_CONT;
      CLS_TEXT:   code = OPC_TEXT;
      CLS_BINARY: code = OPC_BINARY;
      CLS_CLOSE:  code = OPC_CLOSE;
      CLS_PING:   code = OPC_PING;
      CLS_PONG:   code = OPC_PONG;
      default:    code = OPC_UNKNOWN;
    endcase
    return code;
  endfunction

  function automatic logic [3:0] ext_bytes(input len_kind_t kind);
    logic [3:0] n;
    unique case (kind)
      LEN_16:  n = EXT_BYTES_16;
      LEN_64:  n = EXT_BYTES_64;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== design/wsh_parser.sv =====
module wsh_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  output logic              done,
  output wsh_pkg::summary_t summary
);

  logic [3:0]         byte_position;
  logic               fin_seen;
  logic [2:0]         opcode_seen;
  logic               mask_seen;
  wsh_pkg::len_kind_t length_kind;
  logic [63:0]        length_accum;
  logic [31:0]        key_accum;

  logic [3:0]         byte_position_next;
  logic               fin_seen_next;
  logic [2:0]         opcode_seen_next;
  logic               mask_seen_next;
  wsh_pkg::len_kind_t length_kind_next;
  logic [63:0]        length_accum_next;
  logic [31:0]        key_accum_next;
  logic [3:0]         total;

  always_comb begin
    fin_seen_next     = fin_seen;
    opcode_seen_next  = opcode_seen;
    mask_seen_next    = mask_seen;
    length_kind_next  = length_kind;
    length_accum_next = length_accum;
    key_accum_next    = key_accum;
    priority if (byte_position == 4'd0) begin
      fin_seen_next     = rx_byte[7];
      opcode_seen_next  = wsh_pkg::class_of_opcode(rx_byte[3:0]);
      mask_seen_next    = 1'b0;
      length_kind_next  = wsh_pkg::LEN_7;
      length_accum_next = '0;
      key_accum_next    = '0;
    end else if (byte_position == 4'd1) begin
      mask_seen_next = rx_byte[7];
      priority if (rx_byte[6:0] == wsh_pkg::LEN_CODE_16) begin
        length_kind_next  = wsh_pkg::LEN_16;
        length_accum_next = '0;
      end else if (rx_byte[6:0] == wsh_pkg::LEN_CODE_64) begin
        length_kind_next  = wsh_pkg::LEN_64;
        length_accum_next = '0;
      end else begin
        length_kind_next  = wsh_pkg::LEN_7;
        length_accum_next = {57'd0, rx_byte[6:0]};
      end
    end else if (byte_position < 4'(wsh_pkg::HDR_BASE + wsh_pkg::ext_bytes(length_kind))) begin
      length_accum_next = {length_accum[55:0], rx_byte};
    end else begin
      key_accum_next = {key_accum[23:0], rx_byte};
    end
    total = 4'(wsh_pkg::HDR_BASE + wsh_pkg::ext_bytes(length_kind_next)
               + (mask_seen_next ? wsh_pkg::KEY_BYTES : 4'd0));
    done  = (byte_position != 4'd0) && (4'(byte_position + 4'd1) >= total);
    byte_position_next = done ? 4'd0 : 4'(byte_position + 4'd1);
  end

  always_comb begin
    summary.fin          = fin_seen;
    summary.opcode_class = opcode_seen;
    summary.masked       = mask_seen_next;
    summary.length       = length_accum_next;
    summary.key          = mask_seen_next ? key_accum_next : 32'd0;
    summary.header_bytes = total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 4'd0;
      fin_seen      <= 1'b0;
      opcode_seen   <= 3'd0;
      mask_seen     <= 1'b0;
      length_kind   <= wsh_pkg::LEN_7;
      length_accum  <= '0;
      key_accum     <= '0;
    end else if (step) begin
      byte_position <= byte_position_next;
      fin_seen      <= fin_seen_next;
      opcode_seen   <= opcode_seen_next;
      mask_seen     <= mask_seen_next;
      length_kind   <= length_kind_next;
      length_accum  <= length_accum_next;
      key_accum     <= key_accum_next;
    end
  end

endmodule

// ===== design/wsh_encoder.sv =====
module wsh_encoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  wsh_pkg::in_word_t fields,
  output wsh_pkg::enc_out_t enc
);

  logic [3:0]  idx;
  logic [3:0]  ext_n;
  logic [6:0]  len7;
  logic [63:0] ext_val;
  logic [3:0]  ext_pos;
  logic [3:0]  key_pos;
  logic [2:0]  sh;
  logic [1:0]  kj;

  always_comb begin
    priority if (fields.tx_length < wsh_pkg::LEN_LIMIT_7) begin
      ext_n   = 4'd0;
      len7    = fields.tx_length[6:0];
      ext_val = '0;
    end else if (fields.tx_length < wsh_pkg::LEN_LIMIT_16) begin
      ext_n   = wsh_pkg::EXT_BYTES_16;
      len7    = wsh_pkg::LEN_CODE_16;
      ext_val = {48'd0, fields.tx_length[15:0]};
    end else begin
      ext_n   = wsh_pkg::EXT_BYTES_64;
      len7    = wsh_pkg::LEN_CODE_64;
      ext_val = fields.tx_length;
    end
    enc.count = 4'(wsh_pkg::HDR_BASE + ext_n
                   + (fields.tx_masked ? wsh_pkg::KEY_BYTES : 4'd0));
    ext_pos = 4'(idx - wsh_pkg::HDR_BASE);
    key_pos = 4'(ext_pos - ext_n);
    sh      = 3'(ext_n - 4'd1 - ext_pos);
    kj      = key_pos[1:0];
    priority if (idx == 4'd0) begin
      enc.data = {fields.tx_fin, 3'b000,
                  wsh_pkg::opcode_of_class(fields.tx_opcode_class)};
    end else if (idx == 4'd1) begin
      enc.data = {fields.tx_masked, len7};
    end else if (ext_pos < ext_n) begin
      enc.data = ext_val[{sh, 3'b000} +: 8];
    end else begin
      // key goes out most significant byte first
      enc.data = fields.tx_key[{~kj, 3'b000} +: 8];
    end
    enc.last = (idx == 4'(enc.count - 4'd1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 4'd0;
    end else if (advance) begin
      idx <= enc.last ? 4'd0 : 4'(idx + 4'd1);
    end
  end

endmodule

// ===== design/websocket_frame_header_codec.sv =====
// channel | handshake              | payload
// s_axis  | s_axis_tvalid/tready   | tuser = op, tdata = header byte or encode fields
// m_axis  | m_axis_tvalid/tready   | tuser = kind, tlast = last, tdata = result fields
//
// Parse: one word per cycle; the closing byte waits until m_axis registers its summary.
// Encode: 2 to 14 header bytes, one per cycle from the byte counter while m_axis is free.
// Input register holds an encode word until its last byte is loaded out.
// Output register decouples the sides; a full input register stalls s_axis.
// rst is synchronous and clears the parse state, the encode byte counter and both valid flags.
module websocket_frame_header_codec (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // rx_byte, tx_fin, tx_opcode_class, tx_masked, tx_length, tx_key
  input  logic [111:0]  s_axis_tdata,
  // op
  input  logic          s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // tx_byte, rx_fin, rx_opcode_class, rx_masked, rx_length, rx_key, header_bytes
  output logic [119:0]  m_axis_tdata,
  // kind
  output logic          m_axis_tuser,
  output logic          m_axis_tlast
);

  logic                s1_valid;
  wsh_pkg::op_t        s1_op;
  wsh_pkg::in_word_t   s1_word;

  logic                out_free;
  logic                par_step;
  logic                par_done;
  logic                enc_adv;
  logic                s1_release;
  logic                load;
  wsh_pkg::summary_t   summary;
  wsh_pkg::enc_out_t   enc;
  wsh_pkg::out_word_t  out_word_next;
  wsh_pkg::kind_t      kind_next;

  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign par_step   = s1_valid && (s1_op == wsh_pkg::OP_PARSE) && (!par_done || out_free);
  assign enc_adv    = s1_valid && (s1_op == wsh_pkg::OP_ENCODE) && out_free;
  assign s1_release = par_step || (enc_adv && enc.last);
  assign s_axis_tready = !s1_valid || s1_release;
  assign load       = (par_step && par_done) || enc_adv;

  wsh_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (par_step),
    .rx_byte (s1_word.rx_byte),
    .done    (par_done),
    .summary (summary)
  );

  wsh_encoder u_encoder (
    .clk     (clk),
    .rst     (rst),
    .advance (enc_adv),
    .fields  (s1_word),
    .enc     (enc)
  );

  always_comb begin
    out_word_next = '0;
    if (s1_op == wsh_pkg::OP_PARSE) begin
      kind_next                     = wsh_pkg::KIND_SUMMARY;
      out_word_next.rx_fin          = summary.fin;
      out_word_next.rx_opcode_class = summary.opcode_class;
      out_word_next.rx_masked       = summary.masked;
      out_word_next.rx_length       = summary.length;
      out_word_next.rx_key          = summary.key;
      out_word_next.header_bytes    = summary.header_bytes;
    end else begin
      kind_next                  = wsh_pkg::KIND_BYTE;
      out_word_next.tx_byte      = enc.data;
      out_word_next.header_bytes = enc.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_op   <= wsh_pkg::op_t'(s_axis_tuser);
      s1_word <= wsh_pkg::in_word_t'(s_axis_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && load) begin
      m_axis_tdata <= out_word_next;
      m_axis_tuser <= kind_next;
      m_axis_tlast <= (s1_op == wsh_pkg::OP_ENCODE) && enc.last;
    end
  end

endmodule

// ===== design/wsh_checker.sv =====
`include "assert_macros.svh"

module wsh_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [119:0] m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         m_axis_tlast
);

  wsh_pkg::out_word_t ow;
  logic               summary_word;
  logic               mid_byte_taken;

  assign ow             = m_axis_tdata;
  assign summary_word   = m_axis_tvalid && (m_axis_tuser == wsh_pkg::KIND_SUMMARY);
  assign mid_byte_taken = m_axis_tvalid && m_axis_tready && !m_axis_tlast
                          && (m_axis_tuser == wsh_pkg::KIND_BYTE);

  `ASSERT_CLK(a_reset_clears_out, clk, $past(rst) |-> !m_axis_tvalid, "output valid after reset")

  `ASSERT_CLKRST(a_out_holds, clk, rst,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output word dropped while stalled")

  `ASSERT_CLKRST(a_summary_shape, clk, rst,
    summary_word |-> !m_axis_tlast && !ow.header_bytes[0] && (ow.header_bytes != 4'd0)
      && (ow.header_bytes <= 4'd14) && (ow.tx_byte == 8'd0), "malformed header summary")

  `ASSERT_CLKRST(a_header_continues, clk, rst,
    mid_byte_taken |=> m_axis_tvalid && (m_axis_tuser == wsh_pkg::KIND_BYTE)
      && (ow.header_bytes == $past(ow.header_bytes)), "encoded header broken off")

endmodule

bind websocket_frame_header_codec wsh_checker u_wsh_checker (.*);

// ===== tb/tb_websocket_frame_header_codec.sv =====
module tb_websocket_frame_header_codec;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS       = 370;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN       = 16;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    wsh_pkg::kind_t kind;
    logic [7:0]     tx_byte;
    logic           last;
    logic           fin;
    logic [2:0]     cls;
    logic           masked;
    logic [63:0]    length;
    logic [31:0]    key;
    logic [3:0]     hdr_len;
  } result_t;

  class frame_header_tracker;
    logic [3:0]         pos;
    logic               fin_r;
    logic [2:0]         cls_r;
    logic               mask_r;
    wsh_pkg::len_kind_t lkind;
    logic [63:0]        len_acc;
    logic [31:0]        key_acc;
    result_t            pending_out[$];
    int                 errors;

    function new();
      pos     = '0;
      fin_r   = 1'b0;
      cls_r   = '0;
      mask_r  = 1'b0;
      lkind   = wsh_pkg::LEN_7;
      len_acc = '0;
      key_acc = '0;
      errors  = 0;
    endfunction

    function logic [3:0] ext_len(wsh_pkg::len_kind_t k);
      case (k)
        wsh_pkg::LEN_16: return wsh_pkg::EXT_BYTES_16;
        wsh_pkg::LEN_64: return wsh_pkg::EXT_BYTES_64;
        default:         return 4'd0;
      endcase
    endfunction

    function string show(result_t r);
      return {$sformatf("kind=%0d byte=%02h last=%0b fin=%0b cls=%0d mask=%0b ",
                        r.kind, r.tx_byte, r.last, r.fin, r.cls, r.masked),
              $sformatf("len=%016h key=%08h hdr=%0d", r.length, r.key, r.hdr_len)};
    endfunction

    function void accept_word(wsh_pkg::op_t op, wsh_pkg::in_word_t w);
      logic [7:0] b;
      logic [3:0] total;
      logic [7:0] hdr [14];
      logic [3:0] opc;
      int         n;
      result_t    r;
      if (op == wsh_pkg::OP_PARSE) begin
        b = w.rx_byte;
        if (pos == 4'd0) begin
          fin_r = b[7];
          case (b[3:0])
            wsh_pkg::OPC_CONT:   cls_r = wsh_pkg::CLS_CONT;
            wsh_pkg::OPC_TEXT:   cls_r = wsh_pkg::CLS_TEXT;
            wsh_pkg::OPC_BINARY: cls_r = wsh_pkg::CLS_BINARY;
            wsh_pkg::OPC_CLOSE:  cls_r = wsh_pkg::CLS_CLOSE;
            wsh_pkg::OPC_PING:   cls_r = wsh_pkg::CLS_PING;
            wsh_pkg::OPC_PONG:   cls_r = wsh_pkg::CLS_PONG;
            default:             cls_r = wsh_pkg::CLS_UNKNOWN;
          endcase
          mask_r  = 1'b0;
          lkind   = wsh_pkg::LEN_7;
          len_acc = '0;
          key_acc = '0;
          pos     = 4'd1;
          return;
        end
        if (pos == 4'd1) begin
          mask_r = b[7];
          if (b[6:0] == wsh_pkg::LEN_CODE_16) begin
            lkind   = wsh_pkg::LEN_16;
            len_acc = '0;
          end else if (b[6:0] == wsh_pkg::LEN_CODE_64) begin
            lkind   = wsh_pkg::LEN_64;
            len_acc = '0;
          end else begin
            lkind   = wsh_pkg::LEN_7;
            len_acc = {57'd0, b[6:0]};
          end
        end else if (pos < wsh_pkg::HDR_BASE + ext_len(lkind)) begin
          len_acc = {len_acc[55:0], b};
        end else begin
          key_acc = {key_acc[23:0], b};
        end
        total = wsh_pkg::HDR_BASE + ext_len(lkind) + (mask_r ? wsh_pkg::KEY_BYTES : 4'd0);
        if (pos + 4'd1 < total) begin
          pos = pos + 4'd1;
          return;
        end
        pos       = '0;
        r.kind    = wsh_pkg::KIND_SUMMARY;
        r.tx_byte = '0;
        r.last    = 1'b0;
        r.fin     = fin_r;
        r.cls     = cls_r;
        r.masked  = mask_r;
        r.length  = len_acc;
        r.key     = mask_r ? key_acc : 32'd0;
        r.hdr_len = total;
        pending_out.push_back(r);
      end else begin
        case (w.tx_opcode_class)
          wsh_pkg::CLS_CONT:   opc = wsh_pkg::OPC_CONT;
          wsh_pkg::CLS_TEXT:   opc = wsh_pkg::OPC_TEXT;
          wsh_pkg::CLS_BINARY: opc = wsh_pkg::OPC_BINARY;
          wsh_pkg::CLS_CLOSE:  opc = wsh_pkg::OPC_CLOSE;
          wsh_pkg::CLS_PING:   opc = wsh_pkg::OPC_PING;
          wsh_pkg::CLS_PONG:   opc = wsh_pkg::OPC_PONG;
          default:             opc = wsh_pkg::OPC_UNKNOWN;
        endcase
        hdr[0] = {w.tx_fin, 3'b000, opc};
        if (w.tx_length < wsh_pkg::LEN_LIMIT_7) begin
          hdr[1] = {w.tx_masked, w.tx_length[6:0]};
          n = 2;
        end else if (w.tx_length < wsh_pkg::LEN_LIMIT_16) begin
          hdr[1] = {w.tx_masked, wsh_pkg::LEN_CODE_16};
          hdr[2] = w.tx_length[15:8];
          hdr[3] = w.tx_length[7:0];
          n = 4;
        end else begin
          hdr[1] = {w.tx_masked, wsh_pkg::LEN_CODE_64};
          for (int i = 0; i < 8; i++) hdr[2 + i] = 8'(w.tx_length >> (56 - 8 * i));
          n = 10;
        end
        if (w.tx_masked) begin
          for (int i = 0; i < 4; i++) hdr[n + i] = 8'(w.tx_key >> (24 - 8 * i));
          n = n + 4;
        end
        for (int k = 0; k < n; k++) begin
          r.kind    = wsh_pkg::KIND_BYTE;
          r.tx_byte = hdr[k];
          r.last    = (k == n - 1);
          r.fin     = 1'b0;
          r.cls     = '0;
          r.masked  = 1'b0;
          r.length  = '0;
          r.key     = '0;
          r.hdr_len = 4'(n);
          pending_out.push_back(r);
        end
      end
    endfunction

    function void match_word(wsh_pkg::kind_t kind, logic last, wsh_pkg::out_word_t w);
      result_t got;
      result_t want;
      got.kind    = kind;
      got.tx_byte = w.tx_byte;
      got.last    = last;
      got.fin     = w.rx_fin;
      got.cls     = w.rx_opcode_class;
      got.masked  = w.rx_masked;
      got.length  = w.rx_length;
      got.key     = w.rx_key;
      got.hdr_len = w.header_bytes;
      if (pending_out.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: %s", show(got));
        return;
      end
      want = pending_out.pop_front();
      if (got.kind !== want.kind || got.tx_byte !== want.tx_byte || got.last !== want.last ||
          got.fin !== want.fin || got.cls !== want.cls || got.masked !== want.masked ||
          got.length !== want.length || got.key !== want.key ||
          got.hdr_len !== want.hdr_len) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch at %0t", $realtime);
          $display("  exp %s", show(want));
          $display("  got %s", show(got));
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  wsh_pkg::in_word_t  s_axis_tdata;
  logic               s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  wsh_pkg::out_word_t m_axis_tdata;
  logic               m_axis_tuser;
  logic               m_axis_tlast;

  frame_header_tracker sb;
  int words_in;
  int cycles;
  bit hold_done;
  bit src_calm;
  bit sink_calm;

  websocket_frame_header_codec i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(16, 60);
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.accept_word(wsh_pkg::op_t'(s_axis_tuser), s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        sb.match_word(wsh_pkg::kind_t'(m_axis_tuser), m_axis_tlast, m_axis_tdata);
    end
  end

  task automatic send_word(input wsh_pkg::op_t op, input wsh_pkg::in_word_t w);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= w;
    do @(posedge clk); while (!s_axis_tready);
    words_in++;
    if ($urandom_range(0, 31) == 0) src_calm = !src_calm;
    if (!src_calm && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  task automatic send_header_byte(input logic [7:0] b);
    wsh_pkg::in_word_t w;
    w.pad             = '0;
    w.tx_key          = $urandom;
    w.tx_length       = {$urandom, $urandom};
    w.tx_masked       = 1'($urandom);
    w.tx_opcode_class = 3'($urandom);
    w.tx_fin          = 1'($urandom);
    w.rx_byte         = b;
    send_word(wsh_pkg::OP_PARSE, w);
  endtask

  task automatic send_encode(input logic fin, input logic [2:0] cls, input logic masked,
                             input logic [63:0] len, input logic [31:0] key);
    wsh_pkg::in_word_t w;
    w.pad             = '0;
    w.tx_key          = key;
    w.tx_length       = len;
    w.tx_masked       = masked;
    w.tx_opcode_class = cls;
    w.tx_fin          = fin;
    w.rx_byte         = 8'($urandom);
    send_word(wsh_pkg::OP_ENCODE, w);
  endtask

  task automatic send_random_encode();
    logic [63:0] len;
    case ($urandom_range(0, 4))
      0: len = 64'($urandom_range(0, 125));
      1: len = 64'($urandom_range(126, 65535));
      2: begin
        case ($urandom_range(0, 3))
          0:       len = 64'd125;
          1:       len = 64'd126;
          2:       len = 64'hFFFF;
          default: len = 64'h10000;
        endcase
      end
      3: len = {$urandom, $urandom} >> $urandom_range(0, 47);
      default: len = {$urandom, $urandom};
    endcase
    send_encode(1'($urandom), 3'($urandom_range(0, 7)), 1'($urandom), len, $urandom);
  endtask

  task automatic send_random_header();
    logic [7:0]  hdr [14];
    logic [63:0] len;
    logic [31:0] key;
    logic [3:0]  opc;
    logic        mask;
    int          n;
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 5))
        0:       opc = wsh_pkg::OPC_CONT;
        1:       opc = wsh_pkg::OPC_TEXT;
        2:       opc = wsh_pkg::OPC_BINARY;
        3:       opc = wsh_pkg::OPC_CLOSE;
        4:       opc = wsh_pkg::OPC_PING;
        default: opc = wsh_pkg::OPC_PONG;
      endcase
    end else begin
      opc = 4'($urandom);
    end
    hdr[0] = {3'($urandom), 1'($urandom), opc};
    mask   = 1'($urandom);
    case ($urandom_range(0, 2))
      0: begin
        hdr[1] = {mask, 7'($urandom_range(0, 125))};
        n = 2;
      end
      1: begin
        len    = 64'($urandom_range(0, 65535));
        hdr[1] = {mask, wsh_pkg::LEN_CODE_16};
        hdr[2] = len[15:8];
        hdr[3] = len[7:0];
        n = 4;
      end
      default: begin
        len    = {$urandom, $urandom} >> $urandom_range(0, 63);
        hdr[1] = {mask, wsh_pkg::LEN_CODE_64};
        for (int i = 0; i < 8; i++) hdr[2 + i] = 8'(len >> (56 - 8 * i));
        n = 10;
      end
    endcase
    if (mask) begin
      key = $urandom;
      for (int i = 0; i < 4; i++) hdr[n + i] = 8'(key >> (24 - 8 * i));
      n = n + 4;
    end
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) send_random_encode();
      send_header_byte(hdr[k]);
    end
  endtask

  initial begin : sink
    m_axis_tready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 63) == 0) sink_calm = !sink_calm;
      if (!hold_done && words_in >= 60) begin
        m_axis_tready <= 1'b0;
        hold_done = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (sink_calm || $urandom_range(0, 3) != 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        repeat (gap_len() - 1) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stim
    sb            = new();
    words_in      = 0;
    hold_done     = 1'b0;
    src_calm      = 1'b0;
    sink_calm     = 1'b0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= wsh_pkg::OP_PARSE;
    s_axis_tdata  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // encode: length boundaries, every class incl. the unused code, key extremes
    send_encode(1'b1, wsh_pkg::CLS_CONT, 1'b0, 64'd0, 32'h0);
    send_encode(1'b0, wsh_pkg::CLS_TEXT, 1'b1, 64'd125, 32'hFFFF_FFFF);
    send_encode(1'b1, wsh_pkg::CLS_BINARY, 1'b0, 64'd126, 32'h1234_5678);
    send_encode(1'b0, wsh_pkg::CLS_CLOSE, 1'b1, 64'hFFFF, 32'h0);
    send_encode(1'b1, wsh_pkg::CLS_PING, 1'b0, 64'h10000, 32'h0);
    send_encode(1'b1, wsh_pkg::CLS_PONG, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'hA5C3_5A3C);
    send_encode(1'b0, wsh_pkg::CLS_UNKNOWN, 1'b0, 64'h8000_0000_0000_0000, 32'h0);
    send_encode(1'b1, 3'd7, 1'b1, 64'd1, 32'h8000_0001);

    // pong, empty body
    send_header_byte(8'h8A);
    send_header_byte(8'h00);
    // unknown opcode, non-minimal 16-bit length, masked, encode mid-header
    send_header_byte(8'h03);
    send_header_byte(8'hFE);
    send_header_byte(8'h00);
    send_encode(1'b1, wsh_pkg::CLS_TEXT, 1'b1, 64'd300, 32'hCAFE_F00D);
    send_header_byte(8'h05);
    send_header_byte(8'hDE);
    send_header_byte(8'hAD);
    send_header_byte(8'hBE);
    send_header_byte(8'hEF);
    // 64-bit length with top bit set
    send_header_byte(8'hFF);
    send_header_byte(8'h7F);
    for (int i = 0; i < 8; i++) send_header_byte(i == 0 ? 8'h80 : 8'(i * 37));

    while (words_in < ITEMS) begin
      case ($urandom_range(0, 19)) inside
        [0:10]:  send_random_header();
        [11:17]: send_random_encode();
        default: send_header_byte(8'($urandom));
      endcase
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk);

    while (sb.pending_out.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (sb.errors == 0 && sb.pending_out.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
